// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/bce_pkg.sv -----
// ----------------------------------------------------------------------------
// bce_pkg
// types and constants of the bezier curve evaluator
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int CoordW = 24;
    localparam int TimeW  = 17;
    localparam int ScaleW = 24;
    localparam int DeltaW = 16;
    localparam int IdxW   = 4;
    localparam int CfgIdxW = 1;

    localparam logic [TimeW-1:0] TimeOne = 17'h10000;

    localparam logic CfgTimeScale     = 1'b0;
    localparam logic CfgLastPointIdx  = 1'b1;

    localparam logic FuncLoad    = 1'b0;
    localparam logic FuncAdvance = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_PASS,
        ST_OUT
    } state_t;

    // control from sequencer to the cell row
    typedef struct packed {
        logic       load;   // copy control points into the cells
        logic       step;   // one de casteljau pass
        logic [15:0] t;     // curve time q0.16
    } cell_ctrl_t;

    // lerp truncated toward minus infinity
    function automatic logic signed [CoordW-1:0] lerp_floor(
        input logic signed [CoordW-1:0] a,
        input logic signed [CoordW-1:0] b,
        input logic [15:0] t
    );
        logic signed [CoordW:0]    d;
        logic signed [CoordW+17:0] p;
        begin
            d = CoordW'(0) + ($signed({b[CoordW-1], b}) - $signed({a[CoordW-1], a}));
            p = d * $signed({1'b0, t});
            lerp_floor = CoordW'(a + p[CoordW+17:16]);
        end
    endfunction

endpackage

// ----- hdl/bce_cell.sv -----
// ----------------------------------------------------------------------------
// bce_cell
// one interpolation cell: holds a point and lerps toward its right neighbor
// ----------------------------------------------------------------------------
module bce_cell (
    input  logic                                  aclk,
    input  bce_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [bce_pkg::CoordW-1:0]     load_x,
    input  logic signed [bce_pkg::CoordW-1:0]     load_y,
    input  logic signed [bce_pkg::CoordW-1:0]     nbr_x,
    input  logic signed [bce_pkg::CoordW-1:0]     nbr_y,
    output logic signed [bce_pkg::CoordW-1:0]     px,
    output logic signed [bce_pkg::CoordW-1:0]     py
);
    logic signed [bce_pkg::CoordW-1:0] x_reg, y_reg, x_next, y_next;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (ctrl.load) begin
            x_next = load_x;
            y_next = load_y;
        end else if (ctrl.step) begin
            x_next = bce_pkg::lerp_floor(x_reg, nbr_x, ctrl.t);
            y_next = bce_pkg::lerp_floor(y_reg, nbr_y, ctrl.t);
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign px = x_reg;
    assign py = y_reg;
endmodule

// ----- hdl/bezier_curve_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// bezier_curve_evaluator_core
// de casteljau bezier evaluation over a row of interpolation cells
// ----------------------------------------------------------------------------
// channel   direction  tdata / tuser
// s_axis    in         tdata {delta,y,x,idx} tuser func
// m_axis    out        tdata {y,x}           tuser finished
// cfg       in         index 0 time_scale, 1 last_point_index
//
// a load item leaves the core idle for the next item; an advance runs mul, load,
// n passes (n = degree) at one de casteljau pass of the cell row per cycle, then out
// an advance that finishes the curve, or runs at degree zero, skips the passes
// time product is registered in its own cycle before the pass
// reset clears curve time, state, pass count and handshake state, and loads config defaults; points undefined
// the result sits in an output register; a stalled m side holds the item
// ----------------------------------------------------------------------------
module bezier_curve_evaluator_core #(
    parameter int MAX_POINTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // point_index[3:0] point_x[27:4] point_y[51:28] delta[67:52]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pos_x[23:0] pos_y[47:24]
    output logic        m_tuser,   // finished
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CW = bce_pkg::CoordW;
    localparam int NW = $clog2(MAX_POINTS);

    // control point store, written one slot per load item
    logic signed [CW-1:0] mem_x [MAX_POINTS];
    logic signed [CW-1:0] mem_y [MAX_POINTS];

    logic [bce_pkg::ScaleW-1:0] scale_reg;
    logic [3:0]                 lpi_reg;
    logic [bce_pkg::TimeW-1:0]  time_reg, time_next;
    logic [39:0]                prod_reg;
    logic [NW-1:0]              n_reg, cnt_reg, cnt_next;
    bce_pkg::state_t            state_reg, state_next;
    logic                       mv_reg;
    logic [47:0]                md_reg;
    logic                       mf_reg;

    logic                       s_fire;
    logic [3:0]                 in_idx;
    logic signed [CW-1:0]       in_x, in_y;
    logic [15:0]                in_delta;
    logic [NW-1:0]              n_sat;
    logic [bce_pkg::TimeW+1:0]  tsum;
    bce_pkg::cell_ctrl_t        ctrl;

    assign in_idx   = s_tdata[3:0];
    assign in_x     = s_tdata[27:4];
    assign in_y     = s_tdata[51:28];
    assign in_delta = s_tdata[67:52];

    // nothing is taken while reset is held
    assign s_tready  = aresetn && (state_reg == bce_pkg::ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    // degree saturated to the last store index
    assign n_sat = ({28'd0, lpi_reg} > MAX_POINTS - 1) ? NW'(MAX_POINTS - 1) : NW'(lpi_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 24'd65536;
            lpi_reg   <= 4'd3;
        end else if (cfg_valid) begin
            if (cfg_index == bce_pkg::CfgTimeScale) scale_reg <= cfg_data[23:0];
            else                                    lpi_reg   <= cfg_data[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_tuser == bce_pkg::FuncLoad && {28'd0, in_idx} < MAX_POINTS) begin
            mem_x[NW'(in_idx)] <= in_x;
            mem_y[NW'(in_idx)] <= in_y;
        end
    end

    // cell row: cell i takes its neighbor i + 1; the last neighbor is the last cell's own point
    logic signed [CW-1:0] cx [MAX_POINTS+1];
    logic signed [CW-1:0] cy [MAX_POINTS+1];
    assign cx[MAX_POINTS] = cx[MAX_POINTS-1];
    assign cy[MAX_POINTS] = cy[MAX_POINTS-1];

    assign ctrl.load = (state_reg == bce_pkg::ST_LOAD);
    assign ctrl.step = (state_reg == bce_pkg::ST_PASS);
    assign ctrl.t    = time_reg[15:0];

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        bce_cell u_cell (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .load_x (mem_x[i]),
            .load_y (mem_y[i]),
            .nbr_x  (cx[i+1]),
            .nbr_y  (cy[i+1]),
            .px     (cx[i]),
            .py     (cy[i])
        );
    end

    // upper product bits are handled by the saturation test below
    assign tsum = {2'b00, time_reg} + {3'b000, prod_reg[31:16]};

    always_comb begin
        state_next = state_reg;
        time_next  = time_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            bce_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == bce_pkg::FuncAdvance) state_next = bce_pkg::ST_MUL;
                    else if (in_idx == 4'd0) time_next = '0;
                end
            end
            bce_pkg::ST_MUL: begin
                time_next  = (prod_reg[39:32] != 8'd0 || tsum > 19'(bce_pkg::TimeOne))
                             ? bce_pkg::TimeOne : tsum[bce_pkg::TimeW-1:0];
                state_next = bce_pkg::ST_LOAD;
            end
            bce_pkg::ST_LOAD: begin
                cnt_next   = '0;
                state_next = (n_reg == '0 || time_reg[16]) ? bce_pkg::ST_OUT : bce_pkg::ST_PASS;
            end
            bce_pkg::ST_PASS: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == n_reg) state_next = bce_pkg::ST_OUT;
            end
            bce_pkg::ST_OUT: begin
                if (!mv_reg || m_tready) state_next = bce_pkg::ST_IDLE;
            end
            default: state_next = bce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bce_pkg::ST_IDLE;
            time_reg  <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            time_reg  <= time_next;
            cnt_reg   <= cnt_next;
            if (state_reg == bce_pkg::ST_OUT && (!mv_reg || m_tready)) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            prod_reg <= scale_reg * in_delta;
            n_reg    <= n_sat;
        end
        if (state_reg == bce_pkg::ST_OUT && (!mv_reg || m_tready)) begin
            if (time_reg[16]) begin
                md_reg <= {mem_y[n_reg], mem_x[n_reg]};
                mf_reg <= 1'b1;
            end else begin
                md_reg <= {cy[0], cx[0]};
                mf_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mf_reg;

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_time_le_one, aclk, aresetn, 1'b1, time_reg <= bce_pkg::TimeOne)
    `ASSERT_IMPL(a_busy_no_accept, aclk, aresetn, state_reg != bce_pkg::ST_IDLE, !s_tready)
    `ASSERT_NEXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
